// ----- src/serial_gamepad_command_decoder_macros.svh -----
// assertion helpers shared by the decoder rtl
`ifndef SERIAL_GAMEPAD_COMMAND_DECODER_MACROS_SVH
`define SERIAL_GAMEPAD_COMMAND_DECODER_MACROS_SVH

// same-cycle implication
`define SGCD_ASSERT_NOW(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SGCD_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sgcd_pkg.sv -----
`default_nettype none

package sgcd_pkg;

	localparam int unsigned ECHO_REPEATS_DEFAULT = 2;
	localparam int unsigned REPEAT_W = 2;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [7:0] AXIS_NEUTRAL_RESET = 8'd128;
	localparam logic [7:0] HAT_NEUTRAL_RESET = 8'd8;

	localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_NEUTRAL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HAT_NEUTRAL = 1'd1;

	// startup table: nine steps, index SYNC_STEPS means finished
	localparam logic [3:0] SYNC_STEPS = 4'd9;

	localparam logic [5:0] AXIS_LEFT_X = 6'd0;
	localparam logic [5:0] AXIS_LEFT_Y = 6'd1;
	localparam logic [5:0] AXIS_RIGHT_X = 6'd2;

	typedef enum logic {
		CMD_SERIAL = 1'b0,
		CMD_POLL = 1'b1
	} command_t;

	typedef enum logic {
		KIND_ECHO = 1'b0,
		KIND_REPORT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		WORD_NEUTRAL = 2'd0,
		WORD_BUTTONS = 2'd1,
		WORD_AXIS = 2'd2,
		WORD_HAT = 2'd3
	} word_kind_t;

	typedef struct packed {
		logic [13:0] buttons;
		logic [7:0] lx;
		logic [7:0] ly;
		logic [7:0] rx;
		logic [7:0] ry;
		logic [7:0] hat;
	} controls_t;

	function automatic controls_t neutral_controls(input logic [7:0] stick,
			input logic [7:0] hat);
		controls_t c;
		c.buttons = '0;
		c.lx = stick;
		c.ly = stick;
		c.rx = stick;
		c.ry = stick;
		c.hat = hat;
		return c;
	endfunction

	function automatic logic [13:0] sync_buttons(input logic [3:0] idx);
		logic [13:0] b;
		unique case (idx)
			4'd1, 4'd3: b = 14'd48;
			4'd5, 4'd7: b = 14'd4;
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] sync_length(input logic [3:0] idx);
		logic [7:0] n;
		unique case (idx)
			4'd1, 4'd3, 4'd5, 4'd7: n = 8'd5;
			4'd8: n = 8'd250;
			default: n = 8'd50;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- src/serial_gamepad_command_decoder.sv -----
`default_nettype none

// Serial game controller command decoder. Each transaction on the input side is
// either a serial byte or a host report poll; it lands in an input register and
// its result is formed in one pass into an output register, so one transaction
// is taken per clock while the output keeps taking results, and the result is held there.
// While a result waits at the output, one more transaction can enter the input
// register, after which the input stalls until the result is taken.
// After reset a startup table of button presses plays over 470 fresh reports;
// serial bytes arriving before it ends are dropped without an echo. Serial
// frames are a count byte then that many 16-bit words, low byte first, built
// in a shadow copy that goes live only when the frame completes. A poll returns
// a fresh snapshot of the live controls and the next ECHO_REPEATS polls repeat it.
// Register 0 sets the neutral stick axis value and register 1 the neutral hat value.

`include "serial_gamepad_command_decoder_macros.svh"

module serial_gamepad_command_decoder #(
	parameter int unsigned ECHO_REPEATS = sgcd_pkg::ECHO_REPEATS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic in_valid,
	output logic in_ready,
	input wire logic command,
	input wire logic [7:0] byte_value,

	output logic out_valid,
	input wire logic out_ready,
	output logic kind,
	output logic [7:0] echo_byte,
	output logic [13:0] buttons,
	output logic [7:0] left_x,
	output logic [7:0] left_y,
	output logic [7:0] right_x,
	output logic [7:0] right_y,
	output logic [7:0] hat_value,

	input wire logic wr_en,
	input wire logic [sgcd_pkg::CFG_INDEX_W-1:0] wr_index,
	input wire logic [sgcd_pkg::CFG_DATA_W-1:0] wr_data
);
	import sgcd_pkg::*;

	// input stage
	logic valid_s1;
	command_t command_s1;
	logic [7:0] byte_s1;

	// result stage
	logic valid_s2;
	kind_t kind_s2;
	logic [7:0] echo_s2;
	controls_t report_s2;

	// block state
	logic [7:0] axis_neutral_q, hat_neutral_q;
	logic [3:0] sync_index_q, sync_index_nxt;
	logic [7:0] sync_ticks_q, sync_ticks_nxt;
	logic [REPEAT_W-1:0] repeats_left_q, repeats_left_nxt;
	controls_t live_q, live_nxt;
	controls_t shadow_q, shadow_nxt;
	controls_t snapshot_q, snapshot_nxt;
	logic [7:0] words_expected_q, words_expected_nxt;
	logic [7:0] words_seen_q, words_seen_nxt;
	logic low_held_q, low_held_nxt;
	logic [7:0] low_byte_q, low_byte_nxt;

	logic s1_go;
	logic sync_done;
	logic res_valid;
	kind_t res_kind;
	logic [7:0] res_echo;
	controls_t res_ctl;
	logic [7:0] ticks_inc;
	logic [3:0] index_inc;
	logic [7:0] seen_inc;
	controls_t shadow_w;
	logic [5:0] axis_sel;

	assign s1_go = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign sync_done = (sync_index_q == SYNC_STEPS);
	assign ticks_inc = sync_ticks_q + 8'd1;
	assign index_inc = sync_index_q + 4'd1;
	assign seen_inc = words_seen_q + 8'd1;
	assign axis_sel = byte_s1[5:0];

	// word formed from the held low byte and this high byte
	always_comb begin
		shadow_w = shadow_q;
		unique case (word_kind_t'(byte_s1[7:6]))
			WORD_NEUTRAL: shadow_w = neutral_controls(axis_neutral_q, hat_neutral_q);
			WORD_BUTTONS: shadow_w.buttons = {byte_s1[5:0], low_byte_q};
			WORD_AXIS: begin
				priority if (axis_sel == AXIS_LEFT_X) shadow_w.lx = low_byte_q;
				else if (axis_sel == AXIS_LEFT_Y) shadow_w.ly = low_byte_q;
				else if (axis_sel == AXIS_RIGHT_X) shadow_w.rx = low_byte_q;
				else shadow_w.ry = low_byte_q;
			end
			WORD_HAT: shadow_w.hat = low_byte_q;
			default: shadow_w = shadow_q;
		endcase
	end

	always_comb begin
		sync_index_nxt = sync_index_q;
		sync_ticks_nxt = sync_ticks_q;
		repeats_left_nxt = repeats_left_q;
		live_nxt = live_q;
		shadow_nxt = shadow_q;
		snapshot_nxt = snapshot_q;
		words_expected_nxt = words_expected_q;
		words_seen_nxt = words_seen_q;
		low_held_nxt = low_held_q;
		low_byte_nxt = low_byte_q;
		res_valid = 1'b0;
		res_kind = KIND_ECHO;
		res_echo = '0;
		res_ctl = '0;

		if (command_s1 == CMD_POLL) begin
			res_valid = 1'b1;
			res_kind = KIND_REPORT;
			if (repeats_left_q != '0) begin
				res_ctl = snapshot_q;
				repeats_left_nxt = repeats_left_q - REPEAT_W'(1);
			end else begin
				res_ctl = live_q;
				snapshot_nxt = live_q;
				repeats_left_nxt = REPEAT_W'(ECHO_REPEATS);
				if (!sync_done) begin
					if (ticks_inc >= sync_length(sync_index_q)) begin
						sync_ticks_nxt = '0;
						sync_index_nxt = index_inc;
						live_nxt.buttons = sync_buttons(index_inc);
					end else begin
						sync_ticks_nxt = ticks_inc;
					end
				end
			end
		end else if (sync_done) begin
			res_valid = 1'b1;
			res_echo = byte_s1;
			priority if (words_expected_q == '0) begin
				// count byte; zero starts no frame
				if (byte_s1 != '0) begin
					words_expected_nxt = byte_s1;
					words_seen_nxt = '0;
					low_held_nxt = 1'b0;
					shadow_nxt = neutral_controls(axis_neutral_q, hat_neutral_q);
				end
			end else if (!low_held_q) begin
				low_held_nxt = 1'b1;
				low_byte_nxt = byte_s1;
			end else begin
				shadow_nxt = shadow_w;
				low_held_nxt = 1'b0;
				if (seen_inc >= words_expected_q) begin
					live_nxt = shadow_w;
					words_expected_nxt = '0;
					words_seen_nxt = '0;
				end else begin
					words_seen_nxt = seen_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command_t'(command);
			byte_s1 <= byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go) begin
			valid_s2 <= res_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			kind_s2 <= res_kind;
			echo_s2 <= res_echo;
			report_s2 <= res_ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_neutral_q <= AXIS_NEUTRAL_RESET;
			hat_neutral_q <= HAT_NEUTRAL_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_AXIS_NEUTRAL: axis_neutral_q <= wr_data;
				CFG_HAT_NEUTRAL: hat_neutral_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_index_q <= '0;
			sync_ticks_q <= '0;
			repeats_left_q <= '0;
			live_q <= neutral_controls(AXIS_NEUTRAL_RESET, HAT_NEUTRAL_RESET);
			shadow_q <= neutral_controls(AXIS_NEUTRAL_RESET, HAT_NEUTRAL_RESET);
			snapshot_q <= '0;
			words_expected_q <= '0;
			words_seen_q <= '0;
			low_held_q <= 1'b0;
			low_byte_q <= '0;
		end else if (s1_go) begin
			sync_index_q <= sync_index_nxt;
			sync_ticks_q <= sync_ticks_nxt;
			repeats_left_q <= repeats_left_nxt;
			live_q <= live_nxt;
			shadow_q <= shadow_nxt;
			snapshot_q <= snapshot_nxt;
			words_expected_q <= words_expected_nxt;
			words_seen_q <= words_seen_nxt;
			low_held_q <= low_held_nxt;
			low_byte_q <= low_byte_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign kind = kind_s2;
	assign echo_byte = echo_s2;
	assign buttons = report_s2.buttons;
	assign left_x = report_s2.lx;
	assign left_y = report_s2.ly;
	assign right_x = report_s2.rx;
	assign right_y = report_s2.ry;
	assign hat_value = report_s2.hat;

	`SGCD_ASSERT_NOW(a_sync_range, clk, arst_n, 1'b1, sync_index_q <= SYNC_STEPS,
		"startup table index past its end")
	`SGCD_ASSERT_NOW(a_frame_count, clk, arst_n, words_expected_q != '0,
		words_seen_q < words_expected_q, "frame word count overran")
	`SGCD_ASSERT_NOW(a_idle_frame, clk, arst_n, words_expected_q == '0,
		words_seen_q == '0 && !low_held_q, "frame progress left outside a frame")
	`SGCD_ASSERT_NOW(a_repeats_range, clk, arst_n, 1'b1,
		repeats_left_q <= REPEAT_W'(ECHO_REPEATS), "repeat count above setting")
	`SGCD_ASSERT_NEXT(a_drop_in_table, clk, arst_n,
		s1_go && command_s1 == CMD_SERIAL && !sync_done, !valid_s2,
		"serial byte during startup table produced a result")

endmodule

`default_nettype wire
